[rtl/core/sample_dma_buffer_cache_core_macros.svh]
`ifndef SAMPLE_DMA_BUFFER_CACHE_CORE_MACROS_SVH
`define SAMPLE_DMA_BUFFER_CACHE_CORE_MACROS_SVH

// same-cycle implication
`define SDBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sdbc_pkg.sv]
package sdbc_pkg;

  localparam int NB = 16;
  localparam int SW = (NB > 1) ? $clog2(NB) : 1;
  localparam int LW = $clog2(NB + 1);
  localparam int NCW = $clog2(NB + 1);
  localparam logic [LW-1:0] NIL = LW'(NB);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_FRAMES = 1'd1;

  localparam logic [1:0] ST_HIT = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_TICK = 2'd3;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic        op;
    logic [30:0] addr;
    logic [15:0] len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [15:0] offset;
    logic [30:0] fetch_addr;
  } out_item_t;

  typedef struct packed {
    logic          re;
    logic          we_next;
    logic          we_prev;
    logic [SW-1:0] addr;
    logic [LW-1:0] next;
    logic [LW-1:0] prev;
  } link_req_t;

  typedef struct packed {
    logic          re;
    logic          we_start;
    logic          we_last;
    logic [SW-1:0] addr;
    logic [30:0]   start;
    logic [31:0]   last;
  } data_req_t;

  function automatic logic slot_ok(input logic [LW-1:0] s);
    return s < NIL;
  endfunction

  function automatic logic [LW-1:0] rst_next(input logic [SW-1:0] i);
    return ((int'(i) + 1) < NB) ? LW'(int'(i) + 1) : NIL;
  endfunction

  function automatic logic [LW-1:0] rst_prev(input logic [SW-1:0] i);
    return (i == '0) ? NIL : LW'(int'(i) - 1);
  endfunction

endpackage

[rtl/core/sample_dma_buffer_cache_core.sv]
// Sample buffer cache with 16 buffers, one request at a time. A lookup walks
// the in-use list in the link memory, reading each visited buffer and then
// comparing it; a miss then takes the free head and relinks it. A frame tick
// visits every in-use buffer and frees each stale one. Each request ends by
// loading the output register, which waits while a held result is stalled.
// The state sits in two memories with registered reads: a link memory (next
// and previous slot) and a data memory (start address and last-used frame).
`include "sample_dma_buffer_cache_core_macros.svh"

module sample_dma_buffer_cache_core import sdbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0]   buffer_length_r;
  logic [7:0]    stale_frames_r;
  link_req_t     lreq;
  data_req_t     dreq;
  logic [LW-1:0] l_next;
  logic [LW-1:0] l_prev;
  logic [30:0]   d_start;
  logic [31:0]   d_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_length_r <= 16'd1024;
      stale_frames_r <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BUFFER_LENGTH: buffer_length_r <= cfg_wdata;
        REG_STALE_FRAMES:  stale_frames_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  sdbc_link_ram u_link (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (lreq),
    .q_next (l_next),
    .q_prev (l_prev)
  );

  sdbc_data_ram u_data (
    .clk     (clk),
    .req     (dreq),
    .q_start (d_start),
    .q_last  (d_last)
  );

  sdbc_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .buffer_length (buffer_length_r),
    .stale_frames  (stale_frames_r),
    .lreq          (lreq),
    .l_next        (l_next),
    .l_prev        (l_prev),
    .dreq          (dreq),
    .d_start       (d_start),
    .d_last        (d_last)
  );

  `SDBC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted request not held busy")
  `SDBC_ASSERT_NOW(a_hit_no_fetch, out_valid && out_data.status == ST_HIT, out_data.fetch_addr == '0, "hit carries fetch address")
  `SDBC_ASSERT_NOW(a_tick_clean, out_valid && out_data.status == ST_TICK, out_data.slot == '0 && out_data.offset == '0, "tick result has slot or offset")

endmodule

[rtl/core/sdbc_link_ram.sv]
module sdbc_link_ram import sdbc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  link_req_t     req,
  output logic [LW-1:0] q_next,
  output logic [LW-1:0] q_prev
);

  logic [2*LW-1:0] mem [NB];
  logic [NB-1:0]   vld_r;
  logic [2*LW-1:0] rd_r;
  logic            rd_vld_r;
  logic [SW-1:0]   rd_addr_r;

  always_ff @(posedge clk) begin
    if (req.we_next || (req.we_prev && !vld_r[req.addr])) begin
      mem[req.addr][2*LW-1:LW] <= req.we_next ? req.next : rst_next(req.addr);
    end
    if (req.we_prev || (req.we_next && !vld_r[req.addr])) begin
      mem[req.addr][LW-1:0] <= req.we_prev ? req.prev : rst_prev(req.addr);
    end
    if (req.re) begin
      rd_r      <= mem[req.addr];
      rd_vld_r  <= vld_r[req.addr];
      rd_addr_r <= req.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we_next || req.we_prev) begin
      vld_r[req.addr] <= 1'b1;
    end
  end

  assign q_next = rd_vld_r ? rd_r[2*LW-1:LW] : rst_next(rd_addr_r);
  assign q_prev = rd_vld_r ? rd_r[LW-1:0] : rst_prev(rd_addr_r);

endmodule

[rtl/core/sdbc_data_ram.sv]
module sdbc_data_ram import sdbc_pkg::*; (
  input  logic        clk,
  input  data_req_t   req,
  output logic [30:0] q_start,
  output logic [31:0] q_last
);

  logic [62:0] mem [NB];
  logic [62:0] rd_r;

  always_ff @(posedge clk) begin
    if (req.we_start) begin
      mem[req.addr][62:32] <= req.start;
    end
    if (req.we_last) begin
      mem[req.addr][31:0] <= req.last;
    end
    if (req.re) begin
      rd_r <= mem[req.addr];
    end
  end

  assign q_start = rd_r[62:32];
  assign q_last  = rd_r[31:0];

endmodule

[rtl/core/sdbc_seq.sv]
module sdbc_seq import sdbc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_item_t      in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output out_item_t     out_data,
  input  logic [15:0]   buffer_length,
  input  logic [7:0]    stale_frames,
  output link_req_t     lreq,
  input  logic [LW-1:0] l_next,
  input  logic [LW-1:0] l_prev,
  output data_req_t     dreq,
  input  logic [30:0]   d_start,
  input  logic [31:0]   d_last
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_L_RD    = 5'd1;
  localparam logic [4:0] S_L_DAT   = 5'd2;
  localparam logic [4:0] S_M_RD    = 5'd3;
  localparam logic [4:0] S_M_DAT   = 5'd4;
  localparam logic [4:0] S_U1      = 5'd5;
  localparam logic [4:0] S_U2      = 5'd6;
  localparam logic [4:0] S_BR      = 5'd7;
  localparam logic [4:0] S_LA_RD   = 5'd8;
  localparam logic [4:0] S_LA_DAT  = 5'd9;
  localparam logic [4:0] S_LA_W2   = 5'd10;
  localparam logic [4:0] S_LA_W3   = 5'd11;
  localparam logic [4:0] S_HEAD_W1 = 5'd12;
  localparam logic [4:0] S_HEAD_W2 = 5'd13;
  localparam logic [4:0] S_SOLO    = 5'd14;
  localparam logic [4:0] S_FIN     = 5'd15;
  localparam logic [4:0] S_T_RD    = 5'd16;
  localparam logic [4:0] S_T_DAT   = 5'd17;
  localparam logic [4:0] S_OUT     = 5'd18;

  logic [4:0]     state_r, state_nxt;
  logic           op_r, op_nxt;
  logic [30:0]    addr_r, addr_nxt;
  logic [15:0]    len_r, len_nxt;
  logic [LW-1:0]  cur_r, cur_nxt;
  logic [NCW-1:0] n_r, n_nxt;
  logic [LW-1:0]  last_r, last_nxt;
  logic [LW-1:0]  x_r, x_nxt;
  logic [LW-1:0]  xn_r, xn_nxt;
  logic [LW-1:0]  xp_r, xp_nxt;
  logic [LW-1:0]  after_r, after_nxt;
  logic [LW-1:0]  n2_r, n2_nxt;
  logic [LW-1:0]  tnxt_r, tnxt_nxt;
  logic [LW-1:0]  uh_r, uh_nxt;
  logic [LW-1:0]  fh_r, fh_nxt;
  logic [31:0]    fc_r, fc_nxt;
  out_item_t      res_r, res_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_r, out_nxt;

  logic        walk_end;
  logic [31:0] req_end;
  logic [31:0] buf_end;
  logic [31:0] stale_sum;

  assign walk_end  = !slot_ok(cur_r) || (n_r == NCW'(NB));
  assign req_end   = {1'b0, addr_r} + {16'd0, len_r};
  assign buf_end   = {1'b0, d_start} + {16'd0, buffer_length};
  assign stale_sum = d_last + {24'd0, stale_frames};

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    addr_nxt = addr_r;
    len_nxt = len_r;
    cur_nxt = cur_r;
    n_nxt = n_r;
    last_nxt = last_r;
    x_nxt = x_r;
    xn_nxt = xn_r;
    xp_nxt = xp_r;
    after_nxt = after_r;
    n2_nxt = n2_r;
    tnxt_nxt = tnxt_r;
    uh_nxt = uh_r;
    fh_nxt = fh_r;
    fc_nxt = fc_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    lreq = '0;
    dreq = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_data.op;
          addr_nxt = in_data.addr;
          len_nxt = in_data.len;
          cur_nxt = uh_r;
          n_nxt = '0;
          last_nxt = NIL;
          state_nxt = (in_data.op == OP_TICK) ? S_T_RD : S_L_RD;
        end
      end
      S_L_RD: begin
        if (walk_end) begin
          state_nxt = S_M_RD;
        end else begin
          lreq.re = 1'b1;
          lreq.addr = cur_r[SW-1:0];
          dreq.re = 1'b1;
          dreq.addr = cur_r[SW-1:0];
          state_nxt = S_L_DAT;
        end
      end
      S_L_DAT: begin
        if (d_start > addr_r) begin
          state_nxt = S_M_RD;
        end else if (req_end <= buf_end) begin
          dreq.we_last = 1'b1;
          dreq.addr = cur_r[SW-1:0];
          dreq.last = fc_r;
          res_nxt = '{status: ST_HIT, slot: 4'(cur_r), offset: 16'(addr_r - d_start),
                      fetch_addr: '0};
          state_nxt = S_OUT;
        end else begin
          last_nxt = cur_r;
          cur_nxt = l_next;
          n_nxt = n_r + NCW'(1);
          state_nxt = S_L_RD;
        end
      end
      S_M_RD: begin
        if (!slot_ok(fh_r)) begin
          res_nxt = '{status: ST_FULL, slot: slot_ok(uh_r) ? 4'(uh_r) : 4'd0,
                      offset: '0, fetch_addr: '0};
          state_nxt = S_OUT;
        end else begin
          lreq.re = 1'b1;
          lreq.addr = fh_r[SW-1:0];
          x_nxt = fh_r;
          state_nxt = S_M_DAT;
        end
      end
      S_M_DAT: begin
        xn_nxt = l_next;
        xp_nxt = l_prev;
        fh_nxt = l_next;
        state_nxt = S_U1;
      end
      S_U1: begin
        if (slot_ok(xn_r)) begin
          lreq.we_prev = 1'b1;
          lreq.addr = xn_r[SW-1:0];
          lreq.prev = xp_r;
        end
        state_nxt = S_U2;
      end
      S_U2: begin
        if (slot_ok(xp_r)) begin
          lreq.we_next = 1'b1;
          lreq.addr = xp_r[SW-1:0];
          lreq.next = xn_r;
        end
        state_nxt = S_BR;
      end
      S_BR: begin
        if (op_r == OP_TICK) begin
          if (slot_ok(fh_r)) begin
            after_nxt = fh_r;
            state_nxt = S_LA_RD;
          end else begin
            state_nxt = S_SOLO;
          end
        end else begin
          priority if (slot_ok(last_r)) begin
            after_nxt = last_r;
            state_nxt = S_LA_RD;
          end else if (slot_ok(uh_r)) begin
            state_nxt = S_HEAD_W1;
          end else begin
            state_nxt = S_SOLO;
          end
        end
      end
      S_LA_RD: begin
        lreq.re = 1'b1;
        lreq.addr = after_r[SW-1:0];
        state_nxt = S_LA_DAT;
      end
      S_LA_DAT: begin
        n2_nxt = l_next;
        lreq.we_next = 1'b1;
        lreq.we_prev = 1'b1;
        lreq.addr = x_r[SW-1:0];
        lreq.next = l_next;
        lreq.prev = after_r;
        state_nxt = S_LA_W2;
      end
      S_LA_W2: begin
        if (slot_ok(n2_r)) begin
          lreq.we_prev = 1'b1;
          lreq.addr = n2_r[SW-1:0];
          lreq.prev = x_r;
        end
        state_nxt = S_LA_W3;
      end
      S_LA_W3: begin
        lreq.we_next = 1'b1;
        lreq.addr = after_r[SW-1:0];
        lreq.next = x_r;
        if (op_r == OP_TICK) begin
          cur_nxt = tnxt_r;
          n_nxt = n_r + NCW'(1);
          state_nxt = S_T_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_HEAD_W1: begin
        lreq.we_next = 1'b1;
        lreq.we_prev = 1'b1;
        lreq.addr = x_r[SW-1:0];
        lreq.next = uh_r;
        lreq.prev = NIL;
        state_nxt = S_HEAD_W2;
      end
      S_HEAD_W2: begin
        lreq.we_prev = 1'b1;
        lreq.addr = uh_r[SW-1:0];
        lreq.prev = x_r;
        uh_nxt = x_r;
        state_nxt = S_FIN;
      end
      S_SOLO: begin
        lreq.we_next = 1'b1;
        lreq.we_prev = 1'b1;
        lreq.addr = x_r[SW-1:0];
        lreq.next = NIL;
        lreq.prev = NIL;
        if (op_r == OP_TICK) begin
          fh_nxt = x_r;
          cur_nxt = tnxt_r;
          n_nxt = n_r + NCW'(1);
          state_nxt = S_T_RD;
        end else begin
          uh_nxt = x_r;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        dreq.we_start = 1'b1;
        dreq.we_last = 1'b1;
        dreq.addr = x_r[SW-1:0];
        dreq.start = {addr_r[30:1], 1'b0};
        dreq.last = fc_r;
        res_nxt = '{status: ST_MISS, slot: 4'(x_r), offset: {15'd0, addr_r[0]},
                    fetch_addr: {addr_r[30:1], 1'b0}};
        state_nxt = S_OUT;
      end
      S_T_RD: begin
        if (walk_end) begin
          fc_nxt = fc_r + 32'd1;
          res_nxt = '{status: ST_TICK, slot: '0, offset: '0, fetch_addr: '0};
          state_nxt = S_OUT;
        end else begin
          lreq.re = 1'b1;
          lreq.addr = cur_r[SW-1:0];
          dreq.re = 1'b1;
          dreq.addr = cur_r[SW-1:0];
          state_nxt = S_T_DAT;
        end
      end
      S_T_DAT: begin
        tnxt_nxt = l_next;
        if (stale_sum < fc_r) begin
          x_nxt = cur_r;
          xn_nxt = l_next;
          xp_nxt = l_prev;
          if (uh_r == cur_r) begin
            uh_nxt = l_next;
          end
          state_nxt = S_U1;
        end else begin
          cur_nxt = l_next;
          n_nxt = n_r + NCW'(1);
          state_nxt = S_T_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      uh_r <= NIL;
      fh_r <= '0;
      fc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      uh_r <= uh_nxt;
      fh_r <= fh_nxt;
      fc_r <= fc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    addr_r <= addr_nxt;
    len_r <= len_nxt;
    cur_r <= cur_nxt;
    n_r <= n_nxt;
    last_r <= last_nxt;
    x_r <= x_nxt;
    xn_r <= xn_nxt;
    xp_r <= xp_nxt;
    after_r <= after_nxt;
    n2_r <= n2_nxt;
    tnxt_r <= tnxt_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

endmodule
